// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ECD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ecd check failed");

// Check on every clock edge, reset included.
`define ECD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("ecd check failed");

`endif

// File: rtl/ecd_pkg.sv
package ecd_pkg;

   localparam int DAY_STAGES  = 4;
   localparam int TAIL_STAGES = 7;
   localparam int NUM_STAGES  = DAY_STAGES + TAIL_STAGES;

   // Accepted span: 0000-01-01T00:00:00.000 to 9999-12-31T23:59:59.999
   localparam logic signed [48:0] MS_LOW    = -49'sd62167219200000;
   localparam logic signed [48:0] MS_HIGH   = 49'sd253402300799999;
   // MS_LOW is a whole number of days, so the offset keeps day boundaries
   localparam logic [48:0]        MS_OFFSET = 49'd62167219200000;

   // Odd parts of the divisors; the power-of-two parts are bit slices
   localparam logic [17:0] DAY_DIV    = 18'd84375;   // 86400000 / 1024
   localparam logic [17:0] HOUR_DIV   = 18'd28125;   // 3600000 / 128
   localparam logic [17:0] MINUTE_DIV = 18'd1875;    // 60000 / 32
   localparam logic [17:0] SECOND_DIV = 18'd125;     // 1000 / 8
   localparam logic [17:0] ERA_DIV    = 18'd146097;
   localparam logic [17:0] YEAR_DIV   = 18'd365;     // also 1460 / 4
   localparam logic [17:0] CENT_DIV   = 18'd9131;    // 36524 / 4
   localparam logic [17:0] MONTH_DIV  = 18'd153;
   localparam logic [17:0] DOE_LAST   = 18'd146096;

   // Day number from 0000-01-01, moved to 0000-03-01 and one era up
   localparam logic [21:0] ERA_SHIFT  = 22'd146037;

   typedef struct packed {
      logic [21:0] days;
      logic [26:0] tod;
      logic        out_of_range;
   } day_split_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [9:0] millisecond;
   } clock_fields_type;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_fields_type;

   // One restoring division step: shift in a bit, subtract if it fits.
   // Returns {quotient bit, new remainder}; rem must be below dv.
   function automatic logic [18:0] div_step(input logic [17:0] rem,
                                            input logic        nb,
                                            input logic [17:0] dv);
      logic [18:0] t;
      logic [18:0] diff;
      t    = {rem, nb};
      diff = t - {1'b0, dv};
      if (t >= {1'b0, dv}) begin
         div_step = {1'b1, diff[17:0]};
      end else begin
         div_step = {1'b0, t[17:0]};
      end
   endfunction

   // First day of each March-based month: (153 * mp + 2) / 5
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      case (mp)
         4'd0:    month_start = 9'd0;
         4'd1:    month_start = 9'd31;
         4'd2:    month_start = 9'd61;
         4'd3:    month_start = 9'd92;
         4'd4:    month_start = 9'd122;
         4'd5:    month_start = 9'd153;
         4'd6:    month_start = 9'd184;
         4'd7:    month_start = 9'd214;
         4'd8:    month_start = 9'd245;
         4'd9:    month_start = 9'd275;
         4'd10:   month_start = 9'd306;
         4'd11:   month_start = 9'd337;
         default: month_start = 9'd0;
      endcase
   endfunction

endpackage

// File: rtl/epoch_ms_to_civil_datetime_unit.sv
// Throughput: one beat per cycle while rsp_ready is high or the pipeline
// has bubbles; most of the 11 stages hold a few restoring steps of a
// constant division (day split, era, year, month, hour, minute, second).
// Each stage advances when it is empty or the next stage advances, so
// bubbles close up while a rsp beat waits.
// Reset clears the stage valid bits only; data registers are not reset.
module epoch_ms_to_civil_datetime_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [48:0] req_epoch_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [13:0]        rsp_year,
   output logic [3:0]         rsp_month,
   output logic [4:0]         rsp_day,
   output logic [4:0]         rsp_hour,
   output logic [5:0]         rsp_minute,
   output logic [5:0]         rsp_second,
   output logic [9:0]         rsp_millisecond,
   output logic               rsp_out_of_range
);

   localparam int NS = ecd_pkg::NUM_STAGES;
   localparam int DS = ecd_pkg::DAY_STAGES;
   localparam int TS = ecd_pkg::TAIL_STAGES;

   logic [NS-1:0] valid_ff, valid_in;
   logic [NS-1:0] stage_en;
   logic [TS-1:0] oor_ff;

   ecd_pkg::day_split_type    split;
   ecd_pkg::clock_fields_type clk_fields;
   ecd_pkg::date_fields_type  date_fields;

   always_comb begin
      stage_en[NS-1] = !valid_ff[NS-1] || rsp_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i + 1];
      end
   end

   assign valid_in  = {valid_ff[NS-2:0], req_valid};
   assign req_ready = stage_en[0];
   assign rsp_valid = valid_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // carry the range flag beside the date and time stages
   always_ff @(posedge clock) begin
      if (stage_en[DS]) begin
         oor_ff[0] <= split.out_of_range;
      end
      for (int k = 1; k < TS; k++) begin
         if (stage_en[DS + k]) begin
            oor_ff[k] <= oor_ff[k - 1];
         end
      end
   end

   ecd_day_split u_day_split (
      .clock    (clock),
      .stage_en (stage_en[DS-1:0]),
      .epoch_ms (req_epoch_ms),
      .split    (split)
   );

   ecd_time_split u_time_split (
      .clock    (clock),
      .stage_en (stage_en[NS-1:DS]),
      .tod      (split.tod),
      .fields   (clk_fields)
   );

   ecd_civil_date u_civil_date (
      .clock    (clock),
      .stage_en (stage_en[NS-1:DS]),
      .days     (split.days),
      .fields   (date_fields)
   );

   // drop every field of an out-of-range beat to zero
   assign rsp_out_of_range = oor_ff[TS-1];
   assign rsp_year         = rsp_out_of_range ? '0 : date_fields.year;
   assign rsp_month        = rsp_out_of_range ? '0 : date_fields.month;
   assign rsp_day          = rsp_out_of_range ? '0 : date_fields.day;
   assign rsp_hour         = rsp_out_of_range ? '0 : clk_fields.hour;
   assign rsp_minute       = rsp_out_of_range ? '0 : clk_fields.minute;
   assign rsp_second       = rsp_out_of_range ? '0 : clk_fields.second;
   assign rsp_millisecond  = rsp_out_of_range ? '0 : clk_fields.millisecond;

endmodule

// File: rtl/ecd_day_split.sv
module ecd_day_split (
   input  logic                              clock,
   input  logic [ecd_pkg::DAY_STAGES-1:0]    stage_en,
   input  logic signed [48:0]                epoch_ms,
   output ecd_pkg::day_split_type            split
);

   logic [48:0] u0_ff, u0_in;
   logic        oor0_ff, oor0_in;

   logic [16:0] rem1_ff, rem1_in;
   logic [7:0]  q1_ff, q1_in;
   logic [23:0] low1_ff, low1_in;
   logic        oor1_ff;

   logic [16:0] rem2_ff, rem2_in;
   logic [15:0] q2_ff, q2_in;
   logic [15:0] low2_ff, low2_in;
   logic        oor2_ff;

   ecd_pkg::day_split_type split_ff, split_in;

   // Range check and offset to a non-negative count from year zero
   always_comb begin
      oor0_in = (epoch_ms < ecd_pkg::MS_LOW) || (epoch_ms > ecd_pkg::MS_HIGH);
      u0_in   = $unsigned(epoch_ms) + ecd_pkg::MS_OFFSET;
   end

   // Divide u[48:10] by 84375; the quotient fits 22 bits, so the top
   // 17 bits start as the remainder.
   always_comb begin : s1_div
      logic [17:0] rem;
      logic [7:0]  q;
      logic [18:0] st;
      rem = {1'b0, u0_ff[48:32]};
      q   = '0;
      for (int i = 7; i >= 0; i--) begin
         st  = ecd_pkg::div_step(rem, u0_ff[24 + i], ecd_pkg::DAY_DIV);
         q   = {q[6:0], st[18]};
         rem = st[17:0];
      end
      rem1_in = rem[16:0];
      q1_in   = q;
      low1_in = u0_ff[23:0];
   end

   always_comb begin : s2_div
      logic [17:0] rem;
      logic [7:0]  q;
      logic [18:0] st;
      rem = {1'b0, rem1_ff};
      q   = '0;
      for (int i = 7; i >= 0; i--) begin
         st  = ecd_pkg::div_step(rem, low1_ff[16 + i], ecd_pkg::DAY_DIV);
         q   = {q[6:0], st[18]};
         rem = st[17:0];
      end
      rem2_in = rem[16:0];
      q2_in   = {q1_ff, q};
      low2_in = low1_ff[15:0];
   end

   always_comb begin : s3_div
      logic [17:0] rem;
      logic [5:0]  q;
      logic [18:0] st;
      rem = {1'b0, rem2_ff};
      q   = '0;
      for (int i = 5; i >= 0; i--) begin
         st  = ecd_pkg::div_step(rem, low2_ff[10 + i], ecd_pkg::DAY_DIV);
         q   = {q[4:0], st[18]};
         rem = st[17:0];
      end
      split_in.days         = {q2_ff, q};
      // time of day: remainder rejoined with the bits under the shift
      split_in.tod          = {rem[16:0], low2_ff[9:0]};
      split_in.out_of_range = oor2_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         u0_ff   <= u0_in;
         oor0_ff <= oor0_in;
      end
      if (stage_en[1]) begin
         rem1_ff <= rem1_in;
         q1_ff   <= q1_in;
         low1_ff <= low1_in;
         oor1_ff <= oor0_ff;
      end
      if (stage_en[2]) begin
         rem2_ff <= rem2_in;
         q2_ff   <= q2_in;
         low2_ff <= low2_in;
         oor2_ff <= oor1_ff;
      end
      if (stage_en[3]) begin
         split_ff <= split_in;
      end
   end

   assign split = split_ff;

endmodule

// File: rtl/ecd_time_split.sv
module ecd_time_split (
   input  logic                              clock,
   input  logic [ecd_pkg::TAIL_STAGES-1:0]   stage_en,
   input  logic [26:0]                       tod,
   output ecd_pkg::clock_fields_type         fields
);

   logic [4:0]  hour0_ff, hour0_in;
   logic [21:0] remh0_ff, remh0_in;

   logic [4:0]  hour1_ff;
   logic [5:0]  minute1_ff, minute1_in;
   logic [15:0] remm1_ff, remm1_in;

   ecd_pkg::clock_fields_type fields2_ff, fields2_in;
   ecd_pkg::clock_fields_type dly_ff [4];

   // hour = (tod >> 7) / 28125
   always_comb begin : hour_div
      logic [17:0] rem;
      logic [4:0]  q;
      logic [18:0] st;
      rem = {3'b000, tod[26:12]};
      q   = '0;
      for (int i = 4; i >= 0; i--) begin
         st  = ecd_pkg::div_step(rem, tod[7 + i], ecd_pkg::HOUR_DIV);
         q   = {q[3:0], st[18]};
         rem = st[17:0];
      end
      hour0_in = q;
      remh0_in = {rem[14:0], tod[6:0]};
   end

   // minute = (ms of hour >> 5) / 1875
   always_comb begin : minute_div
      logic [17:0] rem;
      logic [5:0]  q;
      logic [18:0] st;
      rem = {7'b0, remh0_ff[21:11]};
      q   = '0;
      for (int i = 5; i >= 0; i--) begin
         st  = ecd_pkg::div_step(rem, remh0_ff[5 + i], ecd_pkg::MINUTE_DIV);
         q   = {q[4:0], st[18]};
         rem = st[17:0];
      end
      minute1_in = q;
      remm1_in   = {rem[10:0], remh0_ff[4:0]};
   end

   // second = (ms of minute >> 3) / 125
   always_comb begin : second_div
      logic [17:0] rem;
      logic [5:0]  q;
      logic [18:0] st;
      rem = {11'b0, remm1_ff[15:9]};
      q   = '0;
      for (int i = 5; i >= 0; i--) begin
         st  = ecd_pkg::div_step(rem, remm1_ff[3 + i], ecd_pkg::SECOND_DIV);
         q   = {q[4:0], st[18]};
         rem = st[17:0];
      end
      fields2_in.hour        = hour1_ff;
      fields2_in.minute      = minute1_ff;
      fields2_in.second      = q;
      fields2_in.millisecond = {rem[6:0], remm1_ff[2:0]};
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         hour0_ff <= hour0_in;
         remh0_ff <= remh0_in;
      end
      if (stage_en[1]) begin
         hour1_ff   <= hour0_ff;
         minute1_ff <= minute1_in;
         remm1_ff   <= remm1_in;
      end
      if (stage_en[2]) begin
         fields2_ff <= fields2_in;
      end
      // hold alongside the date path until it finishes
      if (stage_en[3]) begin
         dly_ff[0] <= fields2_ff;
      end
      if (stage_en[4]) begin
         dly_ff[1] <= dly_ff[0];
      end
      if (stage_en[5]) begin
         dly_ff[2] <= dly_ff[1];
      end
      if (stage_en[6]) begin
         dly_ff[3] <= dly_ff[2];
      end
   end

   assign fields = dly_ff[3];

endmodule

// File: rtl/ecd_civil_date.sv
module ecd_civil_date (
   input  logic                              clock,
   input  logic [ecd_pkg::TAIL_STAGES-1:0]   stage_en,
   input  logic [21:0]                       days,
   output ecd_pkg::date_fields_type          fields
);

   logic [4:0]  era0_ff, era0_in;
   logic [17:0] doe0_ff, doe0_in;

   logic [4:0]  era1_ff;
   logic [17:0] doe1_ff;
   logic [6:0]  q1460_1_ff, q1460_1_in;
   logic [2:0]  q36524_1_ff, q36524_1_in;
   logic        last1_ff, last1_in;

   logic [4:0]  era2_ff;
   logic [17:0] doe2_ff;
   logic [8:0]  yrem2_ff, yrem2_in;
   logic [4:0]  yhi2_ff, yhi2_in;
   logic [3:0]  alow2_ff, alow2_in;

   logic [4:0]  era3_ff;
   logic [17:0] doe3_ff;
   logic [8:0]  yoe3_ff, yoe3_in;

   logic [4:0]  era4_ff;
   logic [8:0]  yoe4_ff;
   logic [8:0]  doy4_ff, doy4_in;

   logic [4:0]  era5_ff;
   logic [8:0]  yoe5_ff;
   logic [8:0]  doy5_ff;
   logic [3:0]  mp5_ff, mp5_in;

   ecd_pkg::date_fields_type fields6_ff, fields6_in;

   // era index (one above the true era) and day of era
   always_comb begin : era_div
      logic [21:0] z;
      logic [17:0] rem;
      logic [4:0]  q;
      logic [18:0] st;
      z   = days + ecd_pkg::ERA_SHIFT;
      rem = {1'b0, z[21:5]};
      q   = '0;
      for (int i = 4; i >= 0; i--) begin
         st  = ecd_pkg::div_step(rem, z[i], ecd_pkg::ERA_DIV);
         q   = {q[3:0], st[18]};
         rem = st[17:0];
      end
      era0_in = q;
      doe0_in = rem;
   end

   // doe / 1460, doe / 36524 and the last day of the era
   always_comb begin : leap_terms
      logic [17:0] rem_a;
      logic [17:0] rem_b;
      logic [6:0]  qa;
      logic [2:0]  qb;
      logic [18:0] st;
      rem_a = {9'b0, doe0_ff[17:9]};
      qa    = '0;
      for (int i = 6; i >= 0; i--) begin
         st    = ecd_pkg::div_step(rem_a, doe0_ff[2 + i], ecd_pkg::YEAR_DIV);
         qa    = {qa[5:0], st[18]};
         rem_a = st[17:0];
      end
      rem_b = {5'b0, doe0_ff[17:5]};
      qb    = '0;
      for (int i = 2; i >= 0; i--) begin
         st    = ecd_pkg::div_step(rem_b, doe0_ff[2 + i], ecd_pkg::CENT_DIV);
         qb    = {qb[1:0], st[18]};
         rem_b = st[17:0];
      end
      q1460_1_in  = qa;
      q36524_1_in = qb;
      last1_in    = (doe0_ff == ecd_pkg::DOE_LAST);
   end

   // year of era, upper five quotient bits
   always_comb begin : yoe_hi
      logic [17:0] a;
      logic [17:0] rem;
      logic [4:0]  q;
      logic [18:0] st;
      a   = doe1_ff - {11'b0, q1460_1_ff} + {15'b0, q36524_1_ff} - {17'b0, last1_ff};
      rem = {9'b0, a[17:9]};
      q   = '0;
      for (int i = 4; i >= 0; i--) begin
         st  = ecd_pkg::div_step(rem, a[4 + i], ecd_pkg::YEAR_DIV);
         q   = {q[3:0], st[18]};
         rem = st[17:0];
      end
      yrem2_in = rem[8:0];
      yhi2_in  = q;
      alow2_in = a[3:0];
   end

   always_comb begin : yoe_lo
      logic [17:0] rem;
      logic [3:0]  q;
      logic [18:0] st;
      rem = {9'b0, yrem2_ff};
      q   = '0;
      for (int i = 3; i >= 0; i--) begin
         st  = ecd_pkg::div_step(rem, alow2_ff[i], ecd_pkg::YEAR_DIV);
         q   = {q[2:0], st[18]};
         rem = st[17:0];
      end
      yoe3_in = {yhi2_ff, q};
   end

   // day of year, March based
   always_comb begin : doy_calc
      logic [1:0]  q100;
      logic [17:0] yoe_x365;
      logic [17:0] doy_full;
      if (yoe3_ff >= 9'd300) begin
         q100 = 2'd3;
      end else if (yoe3_ff >= 9'd200) begin
         q100 = 2'd2;
      end else if (yoe3_ff >= 9'd100) begin
         q100 = 2'd1;
      end else begin
         q100 = 2'd0;
      end
      yoe_x365 = {9'b0, yoe3_ff} * ecd_pkg::YEAR_DIV;
      doy_full = doe3_ff - yoe_x365 - {11'b0, yoe3_ff[8:2]} + {16'b0, q100};
      doy4_in  = doy_full[8:0];
   end

   // mp = (5 * doy + 2) / 153
   always_comb begin : month_div
      logic [10:0] t;
      logic [17:0] rem;
      logic [3:0]  q;
      logic [18:0] st;
      t   = {doy4_ff, 2'b00} + {2'b00, doy4_ff} + 11'd2;
      rem = {11'b0, t[10:4]};
      q   = '0;
      for (int i = 3; i >= 0; i--) begin
         st  = ecd_pkg::div_step(rem, t[i], ecd_pkg::MONTH_DIV);
         q   = {q[2:0], st[18]};
         rem = st[17:0];
      end
      mp5_in = q;
   end

   always_comb begin : assemble
      logic [8:0]  dom;
      logic [3:0]  m;
      logic [14:0] y;
      dom = doy5_ff - ecd_pkg::month_start(mp5_ff) + 9'd1;
      if (mp5_ff < 4'd10) begin
         m = mp5_ff + 4'd3;
      end else begin
         m = mp5_ff - 4'd9;
      end
      // era index runs one above the true era; January and February
      // belong to the next civil year
      y = {6'b0, yoe5_ff} + {10'b0, era5_ff} * 15'd400 - 15'd400
          + {14'b0, (m <= 4'd2)};
      fields6_in.year  = y[13:0];
      fields6_in.month = m;
      fields6_in.day   = dom[4:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         era0_ff <= era0_in;
         doe0_ff <= doe0_in;
      end
      if (stage_en[1]) begin
         era1_ff     <= era0_ff;
         doe1_ff     <= doe0_ff;
         q1460_1_ff  <= q1460_1_in;
         q36524_1_ff <= q36524_1_in;
         last1_ff    <= last1_in;
      end
      if (stage_en[2]) begin
         era2_ff  <= era1_ff;
         doe2_ff  <= doe1_ff;
         yrem2_ff <= yrem2_in;
         yhi2_ff  <= yhi2_in;
         alow2_ff <= alow2_in;
      end
      if (stage_en[3]) begin
         era3_ff <= era2_ff;
         doe3_ff <= doe2_ff;
         yoe3_ff <= yoe3_in;
      end
      if (stage_en[4]) begin
         era4_ff <= era3_ff;
         yoe4_ff <= yoe3_ff;
         doy4_ff <= doy4_in;
      end
      if (stage_en[5]) begin
         era5_ff <= era4_ff;
         yoe5_ff <= yoe4_ff;
         doy5_ff <= doy4_ff;
         mp5_ff  <= mp5_in;
      end
      if (stage_en[6]) begin
         fields6_ff <= fields6_in;
      end
   end

   assign fields = fields6_ff;

endmodule

// File: rtl/ecd_checker.sv
`include "assert_macros.svh"

module ecd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [13:0] rsp_year,
   input logic [3:0]  rsp_month,
   input logic [4:0]  rsp_day,
   input logic [4:0]  rsp_hour,
   input logic [5:0]  rsp_minute,
   input logic [5:0]  rsp_second,
   input logic [9:0]  rsp_millisecond,
   input logic        rsp_out_of_range
);

   logic [50:0] rsp_word;
   logic        fields_zero;
   logic        fields_legal;
   logic        feb_short;

   assign rsp_word = {rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute, rsp_second,
                      rsp_millisecond, rsp_out_of_range};

   assign fields_zero = (rsp_year == 14'd0) && (rsp_month == 4'd0) && (rsp_day == 5'd0)
                        && (rsp_hour == 5'd0) && (rsp_minute == 6'd0)
                        && (rsp_second == 6'd0) && (rsp_millisecond == 10'd0);

   assign fields_legal = (rsp_year <= 14'd9999) && (rsp_month >= 4'd1)
                         && (rsp_month <= 4'd12) && (rsp_day >= 5'd1)
                         && (rsp_day <= 5'd31) && (rsp_hour <= 5'd23)
                         && (rsp_minute <= 6'd59) && (rsp_second <= 6'd59)
                         && (rsp_millisecond <= 10'd999);

   assign feb_short = (rsp_month != 4'd2) || (rsp_day <= 5'd29);

   // hold a waiting rsp beat with its payload unchanged
   `ECD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))

   `ECD_ASSERT(a_oor_zero, clock, reset, rsp_valid && rsp_out_of_range |-> fields_zero)

   `ECD_ASSERT(a_fields_legal, clock, reset, rsp_valid && !rsp_out_of_range |-> fields_legal)

   `ECD_ASSERT(a_feb_short, clock, reset, rsp_valid && !rsp_out_of_range |-> feb_short)

   `ECD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind epoch_ms_to_civil_datetime_unit ecd_checker u_ecd_checker (.*);

// File: sim/testbench.sv
module testbench;

   // Span of years 0000 to 9999 in milliseconds around the epoch
   localparam longint FIRST_MS   = -64'sd62167219200000;
   localparam longint LAST_MS    = 64'sd253402300799999;
   localparam longint DAY_MS     = 64'sd86400000;
   localparam longint FIRST_DAY  = -64'sd719528;
   localparam int     HOLD_BEATS = 80;

   typedef struct packed {
      ecd_pkg::date_fields_type  date;
      ecd_pkg::clock_fields_type tod;
      logic                      out_of_range;
   } civil_stamp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [48:0] req_epoch_ms = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [13:0]        rsp_year;
   logic [3:0]         rsp_month;
   logic [4:0]         rsp_day;
   logic [4:0]         rsp_hour;
   logic [5:0]         rsp_minute;
   logic [5:0]         rsp_second;
   logic [9:0]         rsp_millisecond;
   logic               rsp_out_of_range;

   logic signed [48:0] epoch_queue [$];
   civil_stamp_type    pending_stamps [$];
   civil_stamp_type    want;
   int                 n_total = 0;
   int                 n_accepted = 0;
   int                 mismatches = 0;
   logic               req_took = 1'b0;
   int                 phase;
   int                 idle_pct;
   int                 stall_pct;
   int                 hold_left = 0;
   logic               hold_done = 1'b0;

   epoch_ms_to_civil_datetime_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_epoch_ms     (req_epoch_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day          (rsp_day),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .rsp_millisecond  (rsp_millisecond),
      .rsp_out_of_range (rsp_out_of_range)
   );

   function automatic longint floor_quot(input longint a, input longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && ((a < 0) != (b < 0))) begin
         q = q - 1;
      end
      return q;
   endfunction

   function automatic civil_stamp_type civil_from_epoch_ms(input logic signed [48:0] stamp);
      longint          ms, days, tod, era, doe, yoe, doy, mp, yr, mon;
      civil_stamp_type r;
      r  = '0;
      ms = longint'(stamp);
      if (ms < FIRST_MS || ms > LAST_MS) begin
         r.out_of_range = 1'b1;
         return r;
      end
      // floor split keeps the time of day non-negative before the epoch
      days = floor_quot(ms, DAY_MS);
      tod  = ms - days * DAY_MS;
      days = days + 719468;
      era  = floor_quot(days, 146097);
      doe  = days - era * 146097;
      yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      yr   = yoe + era * 400;
      doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp   = (5 * doy + 2) / 153;
      mon  = (mp < 10) ? mp + 3 : mp - 9;
      if (mon <= 2) begin
         yr = yr + 1;
      end
      r.date.year          = yr[13:0];
      r.date.month         = mon[3:0];
      r.date.day           = 5'(doy - (153 * mp + 2) / 5 + 1);
      r.tod.hour           = 5'(tod / 3600000);
      r.tod.minute         = 6'((tod % 3600000) / 60000);
      r.tod.second         = 6'((tod % 60000) / 1000);
      r.tod.millisecond    = 10'(tod % 1000);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] exp_val,
                              input logic [15:0] got_val);
      if (exp_val !== got_val) begin
         mismatches++;
         $display("%0t %s: expected %0d, got %0d", $time, name, exp_val, got_val);
      end
   endtask

   initial begin
      forever #6 clock = ~clock;
   end

   // Stress phases: none, sender idle, receiver stall, both, then the long hold
   always_comb begin
      phase = (n_total == 0) ? 0 : (n_accepted * 5) / n_total;
      if (phase > 4) begin
         phase = 4;
      end
      case (phase)
         1:       begin idle_pct = 65; stall_pct = 0;  end
         2:       begin idle_pct = 0;  stall_pct = 65; end
         3:       begin idle_pct = 15; stall_pct = 15; end
         default: begin idle_pct = 0;  stall_pct = 0;  end
      endcase
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (epoch_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            req_valid    <= 1'b1;
            req_epoch_ms <= epoch_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!hold_done && phase == 4) begin
         // hold off long enough for the pipeline to fill and stall req
         hold_left <= HOLD_BEATS;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      req_took <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pending_stamps.push_back(civil_from_epoch_ms(req_epoch_ms));
            n_accepted <= n_accepted + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_stamps.size() == 0) begin
               mismatches++;
               $display("%0t unexpected rsp beat: expected none, got year %0d", $time,
                        rsp_year);
            end else begin
               want = pending_stamps.pop_front();
               check_field("year", 16'(want.date.year), 16'(rsp_year));
               check_field("month", 16'(want.date.month), 16'(rsp_month));
               check_field("day", 16'(want.date.day), 16'(rsp_day));
               check_field("hour", 16'(want.tod.hour), 16'(rsp_hour));
               check_field("minute", 16'(want.tod.minute), 16'(rsp_minute));
               check_field("second", 16'(want.tod.second), 16'(rsp_second));
               check_field("millisecond", 16'(want.tod.millisecond),
                           16'(rsp_millisecond));
               check_field("out_of_range", 16'(want.out_of_range), 16'(rsp_out_of_range));
            end
         end
      end
   end

   initial begin
      longint          corner_ms [25];
      longint          v;
      longint unsigned r;
      longint          span;
      int              kind;
      corner_ms = '{
         64'sd0, 64'sd1, -64'sd1, 64'sd999, 64'sd1000, 64'sd45296789,
         64'sd86399999, 64'sd86400000, -64'sd86400000, -64'sd86400001,
         -64'sd62167219200000, -64'sd62167219200001,
         64'sd253402300799999, 64'sd253402300800000,
         64'sd281474976710655, -64'sd281474976710656,
         // leap day, century rules and era starts
         64'sd951782400000, 64'sd951868799999, 64'sd951868800000,
         -64'sd2203891200001, -64'sd2203891200000,
         64'sd4107542399999, 64'sd4107542400000,
         -64'sd11670912000001, -64'sd11670912000000
      };
      foreach (corner_ms[i]) begin
         epoch_queue.push_back(corner_ms[i][48:0]);
      end
      span = LAST_MS - FIRST_MS + 1;
      repeat (1950) begin
         kind = $urandom_range(0, 99);
         r    = {$urandom, $urandom};
         if (kind < 55) begin
            v = FIRST_MS + longint'(r % span);
         end else if (kind < 75) begin
            // land on or next to a midnight
            v = (FIRST_DAY + $urandom_range(0, 3652424)) * DAY_MS;
            case ($urandom_range(0, 3))
               0:       v = v - 1;
               1:       v = v + 1;
               2:       v = v + DAY_MS - 1;
               default: ;
            endcase
         end else if (kind < 85) begin
            v = longint'(int'($urandom));
         end else if (kind < 92) begin
            v = (($urandom_range(0, 1) == 1) ? LAST_MS : FIRST_MS)
                + $urandom_range(0, 4000) - 2000;
         end else begin
            v = longint'(signed'(r[48:0]));
         end
         epoch_queue.push_back(v[48:0]);
      end
      n_total = epoch_queue.size();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (n_accepted != n_total) @(posedge clock);
      while (pending_stamps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_stamps.size() == 0) begin
         $display("epoch_ms_to_civil_datetime_unit regression: pass");
      end else begin
         $display("epoch_ms_to_civil_datetime_unit regression: fail");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("epoch_ms_to_civil_datetime_unit regression: fail");
      $finish;
   end

endmodule
